// ===== sv/ftm_pkg.sv =====
// Shared types and constants for the five-tuple rule table.
package ftm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_OUT_W     = 7;
  localparam int OP_W          = 3;
  localparam int IN_DATA_W     = 112;
  localparam int OUT_DATA_W    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_MATCH  = 3'd0,
    OP_ADD    = 3'd1,
    OP_DELETE = 3'd2,
    OP_UPDATE = 3'd3,
    OP_FLUSH  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } key_t;

  // word walking down the cell row, with flags gathered on the way
  typedef struct packed {
    logic vld;
    op_t  op;
    key_t key;
    logic act;
    logic hit;
    logic verdict;
    logic claimed;
  } pass_t;

  // end-of-walk broadcast to the cells
  typedef struct packed {
    logic fin;
    logic commit;
  } ctl_t;

  typedef struct packed {
    status_t              status;
    logic                 verdict;
    logic                 hit;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage

// ===== sv/ftm_cell.sv =====
// One rule-table cell: holds a single entry and passes the word on.
module ftm_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  ftm_pkg::pass_t pass_i,
  input  ftm_pkg::ctl_t  ctl_i,
  output ftm_pkg::pass_t pass_o,
  output logic          pend_o
);

  logic            valid_r, valid_nxt;
  logic            pend_r, pend_nxt;
  ftm_pkg::key_t   key_r, key_nxt;
  logic            verdict_r, verdict_nxt;
  ftm_pkg::pass_t  pass_r, pass_nxt;
  logic            is_lookup;
  logic            match;
  logic            claim;

  always_comb begin
    case (pass_i.op)
      ftm_pkg::OP_MATCH,
      ftm_pkg::OP_ADD,
      ftm_pkg::OP_DELETE,
      ftm_pkg::OP_UPDATE: is_lookup = 1'b1;
      default:            is_lookup = 1'b0;
    endcase
  end

  assign match = pass_i.vld && is_lookup && valid_r && (key_r == pass_i.key);
  // first free cell on the way takes a tentative copy of an add
  assign claim = pass_i.vld && (pass_i.op == ftm_pkg::OP_ADD) && !valid_r && !pass_i.claimed;

  always_comb begin
    pass_nxt         = pass_i;
    pass_nxt.hit     = pass_i.hit | match;
    pass_nxt.verdict = pass_i.verdict |
                       (match && (pass_i.op == ftm_pkg::OP_MATCH) && verdict_r);
    pass_nxt.claimed = pass_i.claimed | claim;

    valid_nxt = valid_r;
    if (ctl_i.commit && pend_r) begin
      valid_nxt = 1'b1;
    end
    if (match && (pass_i.op == ftm_pkg::OP_DELETE)) begin
      valid_nxt = 1'b0;
    end
    if (pass_i.vld && (pass_i.op == ftm_pkg::OP_FLUSH)) begin
      valid_nxt = 1'b0;
    end

    if (ctl_i.fin) begin
      pend_nxt = 1'b0;
    end else if (claim) begin
      pend_nxt = 1'b1;
    end else begin
      pend_nxt = pend_r;
    end

    key_nxt     = claim ? pass_i.key : key_r;
    verdict_nxt = (claim || (match && (pass_i.op == ftm_pkg::OP_UPDATE))) ?
                  pass_i.act : verdict_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
      pass_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    verdict_r <= verdict_nxt;
  end

  assign pass_o = pass_r;
  assign pend_o = pend_r;

endmodule

// ===== sv/ftm_ctrl.sv =====
// Sequencer: launches a word, resolves status and count at the tail, holds the result.
module ftm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ftm_pkg::pass_t tail_i,
  output ftm_pkg::ctl_t  ctl_o,
  output logic           out_tvalid,
  input  logic           out_tready,
  output ftm_pkg::res_t  res_o
);

  ftm_pkg::state_t             state_r, state_nxt;
  logic [ftm_pkg::CNT_W-1:0]   count_r, count_nxt;
  ftm_pkg::res_t               res_r, res_nxt;
  ftm_pkg::res_t               out_res_r, out_res_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic                        load_out;
  ftm_pkg::status_t            status;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftm_pkg::S_IDLE: if (in_tvalid) begin
        state_nxt = ftm_pkg::S_WALK;
      end
      ftm_pkg::S_WALK: if (tail_i.vld) begin
        state_nxt = ftm_pkg::S_DONE;
      end
      ftm_pkg::S_DONE: if (!out_vld_r || out_tready) begin
        state_nxt = ftm_pkg::S_IDLE;
      end
      default: state_nxt = ftm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = (state_r == ftm_pkg::S_IDLE);
    load_out     = (state_r == ftm_pkg::S_DONE) && (!out_vld_r || out_tready);
    ctl_o.fin    = tail_i.vld;
    ctl_o.commit = tail_i.vld && (tail_i.op == ftm_pkg::OP_ADD) &&
                   !tail_i.hit && tail_i.claimed;
  end

  always_comb begin
    status    = ftm_pkg::ST_OK;
    count_nxt = count_r;
    case (tail_i.op)
      ftm_pkg::OP_ADD: begin
        if (tail_i.hit) begin
          status = ftm_pkg::ST_EXISTS;
        end else if (!tail_i.claimed) begin
          status = ftm_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + ftm_pkg::CNT_W'(1);
        end
      end
      ftm_pkg::OP_DELETE: begin
        if (!tail_i.hit) begin
          status = ftm_pkg::ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - ftm_pkg::CNT_W'(1);
        end
      end
      ftm_pkg::OP_UPDATE: if (!tail_i.hit) begin
        status = ftm_pkg::ST_NOT_FOUND;
      end
      ftm_pkg::OP_FLUSH: count_nxt = '0;
      default: status = ftm_pkg::ST_OK;
    endcase

    res_nxt.status      = status;
    res_nxt.verdict     = tail_i.verdict;
    res_nxt.hit         = tail_i.hit;
    res_nxt.entry_count = ftm_pkg::CNT_OUT_W'(count_nxt);

    out_res_nxt = load_out ? res_r : out_res_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ftm_pkg::S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (tail_i.vld) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_i.vld) begin
      res_r <= res_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign res_o      = out_res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ftm_pkg::CNT_W'(ftm_pkg::TABLE_ENTRIES))
    else $error("entry count above table size");

  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.commit |=> count_r == $past(count_r) + ftm_pkg::CNT_W'(1))
    else $error("committed add did not bump the count");
`endif

endmodule

// ===== sv/five_tuple_exact_match_rule_table_top.sv =====
// Top level of the five-tuple exact-match rule table: cell row plus sequencer.
// An accepted input word walks the row of entry cells one cell per cycle, and only one word
//   is in the row at a time: a new word is accepted only after the previous result is loaded.
// Reset (rst_n low, synchronous): all entry valid bits, the entry count, the FSM and the
//   output valid all clear directly; no clearing sweep is needed.
module five_tuple_exact_match_rule_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata, low bit up: protocol[7:0], src_ip[39:8], dst_ip[71:40], sport[87:72],
  //   dport[103:88], rule_action[104], zero fill[111:105]
  input  logic [ftm_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: opcode[2:0]
  input  logic [ftm_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata, low bit up: status[1:0], verdict[2], hit[3], entry_count[10:4], zero fill[15:11]
  output logic [ftm_pkg::OUT_DATA_W-1:0] out_tdata
);

  ftm_pkg::pass_t                    chain [ftm_pkg::TABLE_ENTRIES+1];
  ftm_pkg::ctl_t                     ctl;
  ftm_pkg::res_t                     res;
  logic [ftm_pkg::TABLE_ENTRIES-1:0] pend_v;
  logic [ftm_pkg::TABLE_ENTRIES-1:0] vld_v;

  // head word: the accepted input, flags cleared
  always_comb begin
    chain[0].vld          = in_tvalid && in_tready;
    chain[0].op           = ftm_pkg::op_t'(in_tuser);
    chain[0].key.protocol = in_tdata[7:0];
    chain[0].key.src_ip   = in_tdata[39:8];
    chain[0].key.dst_ip   = in_tdata[71:40];
    chain[0].key.sport    = in_tdata[87:72];
    chain[0].key.dport    = in_tdata[103:88];
    chain[0].act          = in_tdata[104];
    chain[0].hit          = 1'b0;
    chain[0].verdict      = 1'b0;
    chain[0].claimed      = 1'b0;
  end

  // row of entry cells; each looks the word up against its entry and hands it on
  for (genvar i = 0; i < ftm_pkg::TABLE_ENTRIES; i++) begin : g_cell
    ftm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pass_i (chain[i]),
      .ctl_i  (ctl),
      .pass_o (chain[i+1]),
      .pend_o (pend_v[i])
    );
    assign vld_v[i] = chain[i+1].vld;
  end

  // sequencer: status, count, and the add commit broadcast at the tail
  ftm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .tail_i     (chain[ftm_pkg::TABLE_ENTRIES]),
    .ctl_o      (ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_o      (res)
  );

  assign out_tdata = {5'b0, res.entry_count, res.hit, res.verdict, res.status};

`ifndef SYNTHESIS
  a_one_claim: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(pend_v))
    else $error("more than one cell holds a tentative add");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_v))
    else $error("more than one word in the cell row");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_v[0])
    else $error("accepted word did not enter the first cell");
`endif

endmodule
